/* sv/ghrp_pkg.sv */
// Ground height ray probe: shared types, widths and constants.
// Used by the top level, the port checker and the bench; depends on nothing.
`default_nettype none

package ghrp_pkg;

   // Field and datapath widths
   localparam int COORD_W   = 32;   // Q16.16 coordinate
   localparam int NORM_W    = 16;   // Q2.14 normal component
   localparam int EDGE_W    = 33;   // difference of two coordinates
   localparam int SY_W      = 34;   // lifted origin y minus vertex y
   localparam int MPLIER_W  = 34;   // serial multiplier operand
   localparam int ACC_W     = 104;  // accumulator, holds N exactly
   localparam int AUV_W     = 68;   // determinant and barycentric numerators
   localparam int REM_W     = 72;   // divider partial remainder
   localparam int DIST_W    = 32;   // saturated distance
   localparam int SQRT_W    = 64;   // sum of squares
   localparam int NUM_W     = 45;   // normalising dividend
   localparam int HGT_W     = 35;   // height before saturation
   localparam int NORM_BITS = 30;   // magnitudes are brought below 2^30
   localparam int CNT_W     = 6;

   // Step counts (last count value of each iteration)
   localparam logic [CNT_W-1:0] MUL_LAST    = 6'd33;
   localparam logic [CNT_W-1:0] DIV_T_LAST  = 6'd31;
   localparam logic [CNT_W-1:0] DIV_N_LAST  = 6'd14;
   localparam logic [CNT_W-1:0] SQRT_LAST   = 6'd31;

   localparam logic signed [SY_W-1:0] RAY_LIFT = 34'sd6553600;   // 100.0
   localparam logic [NORM_W-1:0]      UNIT_Q14 = 16'd16384;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_Z = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] vertex0_x;
      logic signed [COORD_W-1:0] vertex0_y;
      logic signed [COORD_W-1:0] vertex0_z;
      logic signed [COORD_W-1:0] vertex1_x;
      logic signed [COORD_W-1:0] vertex1_y;
      logic signed [COORD_W-1:0] vertex1_z;
      logic signed [COORD_W-1:0] vertex2_x;
      logic signed [COORD_W-1:0] vertex2_y;
      logic signed [COORD_W-1:0] vertex2_z;
      logic                      last_triangle;
   } req_payload_type;

   typedef struct packed {
      logic                      hit;
      logic signed [COORD_W-1:0] ground_height;
      logic signed [NORM_W-1:0]  normal_x;
      logic signed [NORM_W-1:0]  normal_y;
      logic signed [NORM_W-1:0]  normal_z;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_SETUP, ST_MUL, ST_MUL_DONE, ST_SIGN_FIX, ST_TEST,
      ST_DIV_INIT, ST_DIV, ST_KEEP, ST_ABS, ST_NORM_SHIFT, ST_SQRT,
      ST_NDIV_INIT, ST_COMP_DONE, ST_END, ST_FINISH
   } state_type;

   // Product terms run through the shared multiplier, in order
   typedef enum logic [3:0] {
      OP_A_POS, OP_A_NEG, OP_U_POS, OP_U_NEG, OP_V_POS, OP_V_NEG,
      OP_N_A, OP_N_U, OP_N_V, OP_NX_POS, OP_NX_NEG, OP_NZ_POS, OP_NZ_NEG,
      OP_SQ_X, OP_SQ_Y, OP_SQ_Z
   } op_type;

endpackage

`default_nettype wire

/* sv/ground_height_ray_probe_top.sv */
// Ground height ray probe top level: serial multiply-accumulate, divider and
// square root under one sequencer. Depends on ghrp_pkg.
//
//   channel | ports                          | direction | moves
//   req     | req_valid/req_ready/req_data   | in        | one triangle per transfer
//   rsp     | rsp_valid/rsp_ready/rsp_data   | out       | one result per last triangle
//   csr     | csr_we/csr_addr/csr_wdata      | in        | probe position, no wait
//
// Each of up to 16 products runs through the bit-serial multiplier; t takes one
// divide, the normal a shift search, a 32-step square root and three divides.
// A last triangle emits its result from a final finish state. A new triangle
// is taken only in the idle state.
// Synchronous active-high reset clears the sequencer, the probe position, the
// best-hit state and the result valid flag. A waiting result stalls only the
// end of a last triangle.
`default_nettype none

module ground_height_ray_probe_top (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  ghrp_pkg::req_payload_type     req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output ghrp_pkg::rsp_payload_type           rsp_data,
   input  wire                                 csr_we,
   input  wire  [ghrp_pkg::CSR_IDX_W-1:0]      csr_addr,
   input  wire  [ghrp_pkg::COORD_W-1:0]        csr_wdata
);
   import ghrp_pkg::*;

   // Sequencer
   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0] comp_ff, comp_in;

   // Configuration
   logic signed [COORD_W-1:0] probe_x_ff, probe_x_in;
   logic signed [COORD_W-1:0] probe_y_ff, probe_y_in;
   logic signed [COORD_W-1:0] probe_z_ff, probe_z_in;

   // Triangle operands
   logic signed [EDGE_W-1:0] e1x_ff, e1y_ff, e1z_ff, e2x_ff, e2y_ff, e2z_ff;
   logic signed [EDGE_W-1:0] e1x_in, e1y_in, e1z_in, e2x_in, e2y_in, e2z_in;
   logic signed [EDGE_W-1:0] sx_ff, sz_ff, sx_in, sz_in;
   logic signed [SY_W-1:0]   sy_ff, sy_in;
   logic last_ff, last_in;

   // Multiplier
   logic signed [ACC_W-1:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic [MPLIER_W-1:0] mplier_ff, mplier_in;
   logic mneg_ff, mneg_in;

   // Intermediate terms
   logic signed [AUV_W-1:0] a_ff, a_in, u_ff, u_in, v_ff, v_in;
   logic signed [ACC_W-1:0] n_ff, n_in;
   logic a_neg_ff, a_neg_in;

   // Divider
   logic [REM_W-1:0]  div_rem_ff, div_rem_in;
   logic [DIST_W-1:0] div_lo_ff, div_lo_in, div_q_ff, div_q_in;
   logic [AUV_W-1:0]  div_den_ff, div_den_in;
   logic div_norm_ff, div_norm_in;

   // Normal
   logic [AUV_W-1:0] mag_x_ff, mag_y_ff, mag_z_ff, mag_x_in, mag_y_in, mag_z_in;
   logic sgn_x_ff, sgn_y_ff, sgn_z_ff, sgn_x_in, sgn_y_in, sgn_z_in;
   logic [SQRT_W-1:0] sq_x_ff, sq_r_ff, sq_bit_ff, sq_x_in, sq_r_in, sq_bit_in;

   // Best hit so far
   logic [DIST_W-1:0] best_dist_ff, best_dist_in;
   logic signed [NORM_W-1:0] best_nx_ff, best_ny_ff, best_nz_ff;
   logic signed [NORM_W-1:0] best_nx_in, best_ny_in, best_nz_in;
   logic any_hit_ff, any_hit_in;

   // Output register
   logic rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   // Shared combinational terms
   logic mul_sub;
   logic signed [ACC_W-1:0] mul_sum;
   logic signed [ACC_W-1:0] setup_mc;
   logic [MPLIER_W-1:0] setup_mp;
   logic setup_neg, setup_clr;
   logic signed [AUV_W:0] uv_sum;
   logic in_tri;
   logic t_sat;
   logic [REM_W-1:0] div_trial;
   logic div_ge;
   logic [CNT_W-1:0] div_last;
   logic keep_hit;
   logic [AUV_W-1:0] mag_or;
   logic mag_big;
   logic [SQRT_W-1:0] sq_sum;
   logic sq_ge;
   logic [NORM_BITS-1:0] sel_mag;
   logic [NUM_W-1:0] ndiv_num;
   logic [NORM_W-1:0] norm_q;
   logic norm_sgn;
   logic signed [NORM_W-1:0] norm_val;
   logic signed [HGT_W-1:0] height_raw;
   logic signed [COORD_W-1:0] height_sat;
   logic rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // Multiplier step: the top operand bit carries negative weight
   assign mul_sub = mneg_ff ^ (cnt_ff == MUL_LAST);
   assign mul_sum = mul_sub ? acc_ff - mcand_ff : acc_ff + mcand_ff;

   // Operand selection for each product term
   always_comb begin
      setup_mc  = ACC_W'(e1z_ff);
      setup_mp  = MPLIER_W'(e2x_ff);
      setup_neg = 1'b0;
      setup_clr = 1'b1;
      unique case (op_ff)
         OP_A_POS:  begin setup_mc = ACC_W'(e1z_ff); setup_mp = MPLIER_W'(e2x_ff); end
         OP_A_NEG:  begin
            setup_mc = ACC_W'(e1x_ff); setup_mp = MPLIER_W'(e2z_ff);
            setup_neg = 1'b1; setup_clr = 1'b0;
         end
         OP_U_POS:  begin setup_mc = ACC_W'(sz_ff); setup_mp = MPLIER_W'(e2x_ff); end
         OP_U_NEG:  begin
            setup_mc = ACC_W'(sx_ff); setup_mp = MPLIER_W'(e2z_ff);
            setup_neg = 1'b1; setup_clr = 1'b0;
         end
         OP_V_POS:  begin setup_mc = ACC_W'(sx_ff); setup_mp = MPLIER_W'(e1z_ff); end
         OP_V_NEG:  begin
            setup_mc = ACC_W'(sz_ff); setup_mp = MPLIER_W'(e1x_ff);
            setup_neg = 1'b1; setup_clr = 1'b0;
         end
         OP_N_A:    begin setup_mc = ACC_W'(a_ff); setup_mp = MPLIER_W'(sy_ff); end
         OP_N_U:    begin
            setup_mc = ACC_W'(u_ff); setup_mp = MPLIER_W'(e1y_ff);
            setup_neg = 1'b1; setup_clr = 1'b0;
         end
         OP_N_V:    begin
            setup_mc = ACC_W'(v_ff); setup_mp = MPLIER_W'(e2y_ff);
            setup_neg = 1'b1; setup_clr = 1'b0;
         end
         OP_NX_POS: begin setup_mc = ACC_W'(e1y_ff); setup_mp = MPLIER_W'(e2z_ff); end
         OP_NX_NEG: begin
            setup_mc = ACC_W'(e1z_ff); setup_mp = MPLIER_W'(e2y_ff);
            setup_neg = 1'b1; setup_clr = 1'b0;
         end
         OP_NZ_POS: begin setup_mc = ACC_W'(e1x_ff); setup_mp = MPLIER_W'(e2y_ff); end
         OP_NZ_NEG: begin
            setup_mc = ACC_W'(e1y_ff); setup_mp = MPLIER_W'(e2x_ff);
            setup_neg = 1'b1; setup_clr = 1'b0;
         end
         OP_SQ_X:   begin
            setup_mc = $signed(ACC_W'(mag_x_ff[NORM_BITS-1:0]));
            setup_mp = MPLIER_W'(mag_x_ff[NORM_BITS-1:0]);
         end
         OP_SQ_Y:   begin
            setup_mc = $signed(ACC_W'(mag_y_ff[NORM_BITS-1:0]));
            setup_mp = MPLIER_W'(mag_y_ff[NORM_BITS-1:0]);
            setup_clr = 1'b0;
         end
         OP_SQ_Z:   begin
            setup_mc = $signed(ACC_W'(mag_z_ff[NORM_BITS-1:0]));
            setup_mp = MPLIER_W'(mag_z_ff[NORM_BITS-1:0]);
            setup_clr = 1'b0;
         end
         default:   ;
      endcase
   end

   // Barycentric and distance window, exact with a > 0
   assign uv_sum = (AUV_W+1)'(u_ff) + (AUV_W+1)'(v_ff);
   assign in_tri = !u_ff[AUV_W-1] && !(a_ff < u_ff) && !v_ff[AUV_W-1]
                   && !((AUV_W+1)'(a_ff) < uv_sum) && !(n_ff < ACC_W'(a_ff));
   // t saturates when N >= a * 2^32
   assign t_sat  = $unsigned(n_ff) >= ACC_W'({a_ff, {DIST_W{1'b0}}});

   // Restoring divider step
   assign div_trial = {div_rem_ff[REM_W-2:0], div_lo_ff[DIST_W-1]};
   assign div_ge    = div_trial >= REM_W'(div_den_ff);
   assign div_last  = div_norm_ff ? DIV_N_LAST : DIV_T_LAST;
   assign keep_hit  = !any_hit_ff || (div_q_ff < best_dist_ff);

   // Normal scaling and square root step
   assign mag_or  = mag_x_ff | mag_y_ff | mag_z_ff;
   assign mag_big = |mag_or[AUV_W-1:NORM_BITS];
   assign sq_sum  = sq_r_ff + sq_bit_ff;
   assign sq_ge   = sq_x_ff >= sq_sum;

   always_comb begin
      sel_mag  = mag_x_ff[NORM_BITS-1:0];
      norm_sgn = sgn_x_ff;
      unique case (comp_ff)
         2'd0:    begin sel_mag = mag_x_ff[NORM_BITS-1:0]; norm_sgn = sgn_x_ff; end
         2'd1:    begin sel_mag = mag_y_ff[NORM_BITS-1:0]; norm_sgn = sgn_y_ff; end
         2'd2:    begin sel_mag = mag_z_ff[NORM_BITS-1:0]; norm_sgn = sgn_z_ff; end
         default: ;
      endcase
   end

   // mag * 16384 + floor(len / 2)
   assign ndiv_num = {1'b0, sel_mag, 14'b0} + NUM_W'(sq_r_ff[DIST_W-1:1]);
   assign norm_q   = (div_q_ff > DIST_W'(UNIT_Q14)) ? UNIT_Q14 : div_q_ff[NORM_W-1:0];
   assign norm_val = norm_sgn ? -$signed(norm_q) : $signed(norm_q);

   // Ground height with saturation to 32 bits
   assign height_raw = HGT_W'(probe_y_ff) + HGT_W'(RAY_LIFT)
                       - $signed(HGT_W'(best_dist_ff));
   always_comb begin
      height_sat = height_raw[COORD_W-1:0];
      if (height_raw[HGT_W-1:COORD_W-1] != '0 && height_raw[HGT_W-1:COORD_W-1] != '1) begin
         height_sat = height_raw[HGT_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                          : {1'b0, {(COORD_W-1){1'b1}}};
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_valid) state_in = ST_MUL_SETUP;
         ST_MUL_SETUP:  state_in = ST_MUL;
         ST_MUL:        if (cnt_ff == MUL_LAST) state_in = ST_MUL_DONE;
         ST_MUL_DONE: begin
            priority if (op_ff == OP_A_NEG && acc_ff == '0) state_in = ST_END;
            else if (op_ff == OP_N_V)                      state_in = ST_SIGN_FIX;
            else if (op_ff == OP_NZ_NEG)                   state_in = ST_ABS;
            else if (op_ff == OP_SQ_Z)                     state_in = ST_SQRT;
            else                                           state_in = ST_MUL_SETUP;
         end
         ST_SIGN_FIX:   state_in = ST_TEST;
         ST_TEST:       state_in = in_tri ? ST_DIV_INIT : ST_END;
         ST_DIV_INIT:   state_in = t_sat ? ST_KEEP : ST_DIV;
         ST_DIV: begin
            if (cnt_ff == div_last) state_in = div_norm_ff ? ST_COMP_DONE : ST_KEEP;
         end
         ST_KEEP:       state_in = keep_hit ? ST_MUL_SETUP : ST_END;
         ST_ABS:        state_in = ST_NORM_SHIFT;
         ST_NORM_SHIFT: if (!mag_big) state_in = ST_MUL_SETUP;
         ST_SQRT:       if (cnt_ff == SQRT_LAST) state_in = ST_NDIV_INIT;
         ST_NDIV_INIT:  state_in = ST_DIV;
         ST_COMP_DONE:  if (comp_ff == 2'd2) state_in = ST_END;
                        else state_in = ST_NDIV_INIT;
         ST_END:        state_in = last_ff ? ST_FINISH : ST_IDLE;
         ST_FINISH:     if (rsp_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Datapath next values
   always_comb begin
      op_in = op_ff; cnt_in = cnt_ff; comp_in = comp_ff;
      probe_x_in = probe_x_ff; probe_y_in = probe_y_ff; probe_z_in = probe_z_ff;
      e1x_in = e1x_ff; e1y_in = e1y_ff; e1z_in = e1z_ff;
      e2x_in = e2x_ff; e2y_in = e2y_ff; e2z_in = e2z_ff;
      sx_in = sx_ff; sy_in = sy_ff; sz_in = sz_ff; last_in = last_ff;
      acc_in = acc_ff; mcand_in = mcand_ff; mplier_in = mplier_ff; mneg_in = mneg_ff;
      a_in = a_ff; u_in = u_ff; v_in = v_ff; n_in = n_ff; a_neg_in = a_neg_ff;
      div_rem_in = div_rem_ff; div_lo_in = div_lo_ff; div_q_in = div_q_ff;
      div_den_in = div_den_ff; div_norm_in = div_norm_ff;
      mag_x_in = mag_x_ff; mag_y_in = mag_y_ff; mag_z_in = mag_z_ff;
      sgn_x_in = sgn_x_ff; sgn_y_in = sgn_y_ff; sgn_z_in = sgn_z_ff;
      sq_x_in = sq_x_ff; sq_r_in = sq_r_ff; sq_bit_in = sq_bit_ff;
      best_dist_in = best_dist_ff; any_hit_in = any_hit_ff;
      best_nx_in = best_nx_ff; best_ny_in = best_ny_ff; best_nz_in = best_nz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;

      // Register writes; unknown indexes fall through
      if (csr_we) begin
         unique case (csr_addr)
            CSR_PROBE_X: probe_x_in = csr_wdata;
            CSR_PROBE_Y: probe_y_in = csr_wdata;
            CSR_PROBE_Z: probe_z_in = csr_wdata;
            default:     ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            // Capture edges and origin offset from the current probe
            if (req_valid) begin
               e1x_in = EDGE_W'(req_data.vertex1_x) - EDGE_W'(req_data.vertex0_x);
               e1y_in = EDGE_W'(req_data.vertex1_y) - EDGE_W'(req_data.vertex0_y);
               e1z_in = EDGE_W'(req_data.vertex1_z) - EDGE_W'(req_data.vertex0_z);
               e2x_in = EDGE_W'(req_data.vertex2_x) - EDGE_W'(req_data.vertex0_x);
               e2y_in = EDGE_W'(req_data.vertex2_y) - EDGE_W'(req_data.vertex0_y);
               e2z_in = EDGE_W'(req_data.vertex2_z) - EDGE_W'(req_data.vertex0_z);
               sx_in  = EDGE_W'(probe_x_ff) - EDGE_W'(req_data.vertex0_x);
               sz_in  = EDGE_W'(probe_z_ff) - EDGE_W'(req_data.vertex0_z);
               sy_in  = SY_W'(probe_y_ff) + RAY_LIFT - SY_W'(req_data.vertex0_y);
               last_in = req_data.last_triangle;
               op_in = OP_A_POS;
            end
         end
         ST_MUL_SETUP: begin
            mcand_in  = setup_mc;
            mplier_in = setup_mp;
            mneg_in   = setup_neg;
            if (setup_clr) acc_in = '0;
            cnt_in = '0;
         end
         ST_MUL: begin
            if (mplier_ff[0]) acc_in = mul_sum;
            mcand_in  = {mcand_ff[ACC_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[MPLIER_W-1:1]};
            cnt_in    = cnt_ff + 1'b1;
         end
         ST_MUL_DONE: begin
            unique case (op_ff)
               OP_A_NEG:  a_in = acc_ff[AUV_W-1:0];
               OP_U_NEG:  u_in = acc_ff[AUV_W-1:0];
               OP_V_NEG:  v_in = acc_ff[AUV_W-1:0];
               OP_N_V:    n_in = acc_ff;
               OP_NX_NEG: u_in = acc_ff[AUV_W-1:0];
               OP_NZ_NEG: v_in = acc_ff[AUV_W-1:0];
               OP_SQ_Z: begin
                  sq_x_in   = acc_ff[SQRT_W-1:0];
                  sq_r_in   = '0;
                  sq_bit_in = {2'b01, {(SQRT_W-2){1'b0}}};
                  cnt_in    = '0;
               end
               default:   ;
            endcase
            op_in = op_type'(op_ff + 4'd1);
         end
         ST_SIGN_FIX: begin
            // Make the determinant positive
            a_neg_in = a_ff[AUV_W-1];
            if (a_ff[AUV_W-1]) begin
               a_in = -a_ff; u_in = -u_ff; v_in = -v_ff; n_in = -n_ff;
            end
         end
         ST_TEST: ;
         ST_DIV_INIT: begin
            div_q_in    = t_sat ? '1 : '0;
            div_rem_in  = n_ff[ACC_W-1:DIST_W];
            div_lo_in   = n_ff[DIST_W-1:0];
            div_den_in  = a_ff;
            div_norm_in = 1'b0;
            cnt_in      = '0;
         end
         ST_DIV: begin
            div_rem_in = div_ge ? div_trial - REM_W'(div_den_ff) : div_trial;
            div_q_in   = {div_q_ff[DIST_W-2:0], div_ge};
            div_lo_in  = {div_lo_ff[DIST_W-2:0], 1'b0};
            cnt_in     = cnt_ff + 1'b1;
         end
         ST_KEEP: begin
            if (keep_hit) begin
               best_dist_in = div_q_ff;
               any_hit_in   = 1'b1;
               op_in        = OP_NX_POS;
            end
         end
         ST_ABS: begin
            // n = (nx, a, nz) with the original sign of a
            mag_x_in = u_ff[AUV_W-1] ? -u_ff : u_ff;
            mag_y_in = a_ff;
            mag_z_in = v_ff[AUV_W-1] ? -v_ff : v_ff;
            sgn_x_in = u_ff[AUV_W-1];
            sgn_y_in = a_neg_ff;
            sgn_z_in = v_ff[AUV_W-1];
         end
         ST_NORM_SHIFT: begin
            if (mag_big) begin
               mag_x_in = mag_x_ff >> 1;
               mag_y_in = mag_y_ff >> 1;
               mag_z_in = mag_z_ff >> 1;
            end else begin
               op_in = OP_SQ_X;
            end
         end
         ST_SQRT: begin
            if (sq_ge) begin
               sq_x_in = sq_x_ff - sq_sum;
               sq_r_in = (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_in = sq_r_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            cnt_in    = cnt_ff + 1'b1;
            comp_in   = 2'd0;
         end
         ST_NDIV_INIT: begin
            div_q_in    = '0;
            div_rem_in  = REM_W'(ndiv_num[NUM_W-1:15]);
            div_lo_in   = {ndiv_num[14:0], 17'b0};
            div_den_in  = AUV_W'(sq_r_ff[DIST_W-1:0]);
            div_norm_in = 1'b1;
            cnt_in      = '0;
         end
         ST_COMP_DONE: begin
            unique case (comp_ff)
               2'd0:    best_nx_in = norm_val;
               2'd1:    best_ny_in = norm_val;
               2'd2:    best_nz_in = norm_val;
               default: ;
            endcase
            comp_in = comp_ff + 2'd1;
         end
         ST_END: ;
         ST_FINISH: begin
            // Emit the query result, then clear best-hit state
            if (rsp_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.hit            = any_hit_ff;
               rsp_data_in.ground_height  = any_hit_ff ? height_sat : '0;
               rsp_data_in.normal_x       = best_nx_ff;
               rsp_data_in.normal_y       = best_ny_ff;
               rsp_data_in.normal_z       = best_nz_ff;
               best_dist_in = '1;
               any_hit_in   = 1'b0;
               best_nx_in   = '0;
               best_ny_in   = UNIT_Q14;
               best_nz_in   = '0;
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_A_POS;
         cnt_ff       <= '0;
         comp_ff      <= '0;
         probe_x_ff   <= '0;
         probe_y_ff   <= '0;
         probe_z_ff   <= '0;
         best_dist_ff <= '1;
         any_hit_ff   <= 1'b0;
         best_nx_ff   <= '0;
         best_ny_ff   <= UNIT_Q14;
         best_nz_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         cnt_ff       <= cnt_in;
         comp_ff      <= comp_in;
         probe_x_ff   <= probe_x_in;
         probe_y_ff   <= probe_y_in;
         probe_z_ff   <= probe_z_in;
         best_dist_ff <= best_dist_in;
         any_hit_ff   <= any_hit_in;
         best_nx_ff   <= best_nx_in;
         best_ny_ff   <= best_ny_in;
         best_nz_ff   <= best_nz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      e1x_ff <= e1x_in; e1y_ff <= e1y_in; e1z_ff <= e1z_in;
      e2x_ff <= e2x_in; e2y_ff <= e2y_in; e2z_ff <= e2z_in;
      sx_ff <= sx_in; sy_ff <= sy_in; sz_ff <= sz_in; last_ff <= last_in;
      acc_ff <= acc_in; mcand_ff <= mcand_in; mplier_ff <= mplier_in; mneg_ff <= mneg_in;
      a_ff <= a_in; u_ff <= u_in; v_ff <= v_in; n_ff <= n_in; a_neg_ff <= a_neg_in;
      div_rem_ff <= div_rem_in; div_lo_ff <= div_lo_in; div_q_ff <= div_q_in;
      div_den_ff <= div_den_in; div_norm_ff <= div_norm_in;
      mag_x_ff <= mag_x_in; mag_y_ff <= mag_y_in; mag_z_ff <= mag_z_in;
      sgn_x_ff <= sgn_x_in; sgn_y_ff <= sgn_y_in; sgn_z_ff <= sgn_z_in;
      sq_x_ff <= sq_x_in; sq_r_ff <= sq_r_in; sq_bit_ff <= sq_bit_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

/* sv/ghrp_checker.sv */
// Port-level checks for the ground height ray probe, bound to the top level.
// Depends on ghrp_pkg and ground_height_ray_probe_top.
`default_nettype none

module ghrp_checker (
   input wire                        clock,
   input wire                        reset,
   input wire                        req_valid,
   input wire                        req_ready,
   input wire                        rsp_valid,
   input wire                        rsp_ready,
   input wire ghrp_pkg::rsp_payload_type rsp_data
);
   import ghrp_pkg::*;

   // A stalled result holds
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // A triangle transfer starts a multi-cycle test
   busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready straight after a triangle transfer");

   // A miss reports zero height and the up normal
   miss_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.ground_height == '0
         && rsp_data.normal_x == '0 && rsp_data.normal_z == '0
         && rsp_data.normal_y == $signed(UNIT_Q14))
      else $error("miss result not neutral");

   // Normal components stay within one unit
   normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.normal_x <= $signed(UNIT_Q14)
         && rsp_data.normal_x >= -$signed(UNIT_Q14)
         && rsp_data.normal_y <= $signed(UNIT_Q14)
         && rsp_data.normal_y >= -$signed(UNIT_Q14)
         && rsp_data.normal_z <= $signed(UNIT_Q14)
         && rsp_data.normal_z >= -$signed(UNIT_Q14))
      else $error("normal component out of range");

endmodule

bind ground_height_ray_probe_top ghrp_checker u_ghrp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* tb/ground_height_ray_probe_top_tb.sv */
// Regression bench for the ground height ray probe: random and directed
// triangle queries, checked against a built-in exact-integer predictor.
// Depends on ghrp_pkg and ground_height_ray_probe_top.
`default_nettype none

module ground_height_ray_probe_top_tb;
   import ghrp_pkg::*;

   typedef logic signed [129:0] wide_type;

   // Query predictor and expected-result store
   class ground_probe_board;
      logic signed [31:0] probe_x, probe_y, probe_z;
      logic [31:0]        nearest_dist;
      logic signed [15:0] near_nx, near_ny, near_nz;
      bit                 seen_hit;
      rsp_payload_type    pending_results[$];
      int                 mismatches;

      function void clear_query();
         nearest_dist = '1;
         near_nx = 0; near_ny = 16'sd16384; near_nz = 0;
         seen_hit = 0;
      endfunction

      function void reset_all();
         probe_x = 0; probe_y = 0; probe_z = 0;
         clear_query();
         pending_results.delete();
         mismatches = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
         case (idx)
            CSR_PROBE_X: probe_x = val;
            CSR_PROBE_Y: probe_y = val;
            CSR_PROBE_Z: probe_z = val;
            default: ;
         endcase
      endfunction

      function longint unsigned int_sqrt(longint unsigned x);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // Unit normal in Q2.14 from the exact cross product
      function void make_normal(wide_type nx, wide_type ny, wide_type nz);
         wide_type c[3];
         wide_type m;
         bit s[3];
         longint unsigned mag[3], sum, len, v;
         int k;
         logic signed [15:0] res[3];
         c[0] = nx; c[1] = ny; c[2] = nz;
         for (int i = 0; i < 3; i++) begin
            s[i] = c[i] < 0;
            if (s[i]) c[i] = -c[i];
         end
         m = c[0] | c[1] | c[2];
         k = 0;
         while (m >= (wide_type'(1) <<< 30)) begin
            m = m >>> 1;
            k++;
         end
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            mag[i] = longint'(c[i] >>> k);
            sum += mag[i] * mag[i];
         end
         len = int_sqrt(sum);
         for (int i = 0; i < 3; i++) begin
            v = (len == 0) ? 0 : (mag[i] * 16384 + len / 2) / len;
            if (v > 16384) v = 16384;
            res[i] = s[i] ? -16'(v) : 16'(v);
         end
         near_nx = res[0]; near_ny = res[1]; near_nz = res[2];
      endfunction

      // Note an accepted triangle; queue a result when it closes a query
      function void note_triangle(req_payload_type tri_in);
         longint e1x, e1y, e1z, e2x, e2y, e2z, sx, sy, sz, h;
         wide_type a, u, v, n, q;
         logic [31:0] t_dist;
         rsp_payload_type r;
         e1x = longint'(tri_in.vertex1_x) - longint'(tri_in.vertex0_x);
         e1y = longint'(tri_in.vertex1_y) - longint'(tri_in.vertex0_y);
         e1z = longint'(tri_in.vertex1_z) - longint'(tri_in.vertex0_z);
         e2x = longint'(tri_in.vertex2_x) - longint'(tri_in.vertex0_x);
         e2y = longint'(tri_in.vertex2_y) - longint'(tri_in.vertex0_y);
         e2z = longint'(tri_in.vertex2_z) - longint'(tri_in.vertex0_z);
         sx = longint'(probe_x) - longint'(tri_in.vertex0_x);
         sy = longint'(probe_y) + 6553600 - longint'(tri_in.vertex0_y);
         sz = longint'(probe_z) - longint'(tri_in.vertex0_z);
         a = wide_type'(e1z) * wide_type'(e2x) - wide_type'(e1x) * wide_type'(e2z);
         if (a != 0) begin
            u = wide_type'(sz) * wide_type'(e2x) - wide_type'(sx) * wide_type'(e2z);
            v = wide_type'(sx) * wide_type'(e1z) - wide_type'(sz) * wide_type'(e1x);
            n = wide_type'(sy) * a - u * wide_type'(e1y) - v * wide_type'(e2y);
            if (a < 0) begin
               a = -a; u = -u; v = -v; n = -n;
            end
            if (u >= 0 && u <= a && v >= 0 && u + v <= a && n >= a) begin
               q = n / a;
               t_dist = (q > wide_type'(64'hFFFF_FFFF)) ? '1 : q[31:0];
               if (!seen_hit || t_dist < nearest_dist) begin
                  make_normal(wide_type'(e1y) * wide_type'(e2z)
                                 - wide_type'(e1z) * wide_type'(e2y), a,
                              wide_type'(e1x) * wide_type'(e2y)
                                 - wide_type'(e1y) * wide_type'(e2x));
                  // the ny term must keep the original winding sign
                  if ((wide_type'(e1z) * wide_type'(e2x)
                       - wide_type'(e1x) * wide_type'(e2z)) < 0)
                     near_ny = -near_ny;
                  nearest_dist = t_dist;
                  seen_hit = 1;
               end
            end
         end
         if (!tri_in.last_triangle) return;
         h = 0;
         if (seen_hit) begin
            h = longint'(probe_y) + 6553600 - longint'({32'b0, nearest_dist});
            if (h > 64'sd2147483647) h = 64'sd2147483647;
            if (h < -64'sd2147483648) h = -64'sd2147483648;
         end
         r.hit = seen_hit;
         r.ground_height = h[31:0];
         r.normal_x = near_nx;
         r.normal_y = near_ny;
         r.normal_z = near_nz;
         pending_results = {pending_results, r};
         clear_query();
      endfunction

      // Compare one result transfer with the oldest expectation
      function void check_result(rsp_payload_type got);
         rsp_payload_type exp_r;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            mismatches++;
            return;
         end
         exp_r = pending_results.pop_front();
         if (got.hit !== exp_r.hit) begin
            $display("%0t: hit exp %0d got %0d", $time, exp_r.hit, got.hit);
            mismatches++;
         end
         if (got.ground_height !== exp_r.ground_height) begin
            $display("%0t: ground_height exp %0d got %0d", $time,
                     exp_r.ground_height, got.ground_height);
            mismatches++;
         end
         if (got.normal_x !== exp_r.normal_x) begin
            $display("%0t: normal_x exp %0d got %0d", $time, exp_r.normal_x, got.normal_x);
            mismatches++;
         end
         if (got.normal_y !== exp_r.normal_y) begin
            $display("%0t: normal_y exp %0d got %0d", $time, exp_r.normal_y, got.normal_y);
            mismatches++;
         end
         if (got.normal_z !== exp_r.normal_z) begin
            $display("%0t: normal_z exp %0d got %0d", $time, exp_r.normal_z, got.normal_z);
            mismatches++;
         end
      endfunction
   endclass

   logic            clock, reset;
   logic            req_valid, req_ready;
   req_payload_type req_data;
   logic            rsp_valid, rsp_ready;
   rsp_payload_type rsp_data;
   logic            csr_we;
   logic [CSR_IDX_W-1:0] csr_addr;
   logic [31:0]     csr_wdata;

   ground_probe_board board;
   int burst_left;
   int sent_items;

   ground_height_ray_probe_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("ground_height_ray_probe_top regression: fail");
      $finish;
   end

   // Receiver: stall pattern re-chosen from four modes
   initial begin
      int mode, phase;
      rsp_ready = 0;
      phase = 0;
      mode = 0;
      forever begin
         @(negedge clock);
         if (phase % 64 == 0) mode = $urandom_range(0, 3);
         case (mode)
            0: rsp_ready = 1;
            1: rsp_ready = phase[1];
            2: rsp_ready = ($urandom_range(0, 3) != 0);
            default: rsp_ready = (phase % 64) > 40;
         endcase
         phase++;
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
   end

   // Register write at the falling edge, one cycle wide
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we = 1; csr_addr = idx; csr_wdata = val;
      board.set_reg(idx, val);
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic set_probe(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      write_reg(CSR_PROBE_X, x);
      write_reg(CSR_PROBE_Y, y);
      write_reg(CSR_PROBE_Z, z);
   endtask

   // Send one triangle; bursts of random length separated by random gaps
   task automatic send_triangle(req_payload_type t);
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 30)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid = 1;
      req_data = t;
      do @(posedge clock); while (!req_ready);
      board.note_triangle(t);
      sent_items++;
      @(negedge clock);
      req_valid = 0;
   endtask

   // Wait for every expected result, then let the block settle
   task automatic drain();
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
   endtask

   function automatic logic [31:0] clamp_add(logic signed [31:0] base, longint off);
      longint s;
      s = longint'(base) + off;
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s[31:0];
   endfunction

   // Triangle around the probe column, either winding, at a random height
   function automatic req_payload_type hit_triangle(bit last, int span);
      req_payload_type t;
      longint y;
      int d;
      d = $urandom_range(1, span);
      y = longint'(board.probe_y) - longint'($urandom_range(0, 32'h00FF_FFFF))
          + $signed($urandom_range(0, 16'hFFFF)) - 100;
      t.vertex0_x = clamp_add(board.probe_x, -longint'($urandom_range(1, d)));
      t.vertex0_z = clamp_add(board.probe_z, -longint'($urandom_range(1, d)));
      t.vertex1_x = clamp_add(board.probe_x, longint'($urandom_range(1, d)));
      t.vertex1_z = clamp_add(board.probe_z, -longint'($urandom_range(1, d)));
      t.vertex2_x = clamp_add(board.probe_x, $signed($urandom_range(0, 2)) - 1);
      t.vertex2_z = clamp_add(board.probe_z, longint'($urandom_range(1, d)));
      t.vertex0_y = clamp_add(32'(y), $signed($urandom_range(0, 2 * d)) - d);
      t.vertex1_y = clamp_add(32'(y), $signed($urandom_range(0, 2 * d)) - d);
      t.vertex2_y = clamp_add(32'(y), $signed($urandom_range(0, 2 * d)) - d);
      if ($urandom_range(0, 1)) begin
         {t.vertex1_x, t.vertex1_y, t.vertex1_z, t.vertex2_x, t.vertex2_y, t.vertex2_z} =
            {t.vertex2_x, t.vertex2_y, t.vertex2_z, t.vertex1_x, t.vertex1_y, t.vertex1_z};
      end
      t.last_triangle = last;
      return t;
   endfunction

   function automatic req_payload_type noise_triangle(bit last);
      req_payload_type t;
      t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, 1'b0};
      t.last_triangle = last;
      return t;
   endfunction

   // One query: well-formed hits mostly, with broken and degenerate items
   task automatic random_query();
      int len, kind, span;
      req_payload_type t;
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
         kind = $urandom_range(0, 9);
         span = ($urandom_range(0, 3) == 0) ? 32'h7FFF_FFFF : 32'h0003_0000;
         t = hit_triangle(i == len - 1, span);
         if (kind == 0) t = noise_triangle(i == len - 1);
         else if (kind == 1) begin
            t.vertex1_x = t.vertex0_x; t.vertex2_x = t.vertex0_x;   // parallel
         end else if (kind == 2) begin
            t.vertex0_x = clamp_add(board.probe_x, 32'h0010_0000);   // off to one side
         end
         send_triangle(t);
      end
   endtask

   initial begin
      req_payload_type t;
      board = new();
      board.reset_all();
      reset = 1;
      req_valid = 0; req_data = '0; csr_we = 0; csr_addr = '0; csr_wdata = '0;
      burst_left = 0;
      sent_items = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: plain hit, miss, parallel, grazing origin, nearer replace, extremes
      t = '0;
      t.vertex0_x = -32'sd65536; t.vertex0_z = -32'sd65536;
      t.vertex1_x = 32'sd65536;  t.vertex1_z = -32'sd65536;
      t.vertex2_z = 32'sd65536;  t.last_triangle = 1;
      send_triangle(t);
      t.vertex0_x = 32'sd131072; send_triangle(t);
      t = hit_triangle(0, 65536); t.vertex2_x = t.vertex0_x; t.vertex1_x = t.vertex0_x;
      send_triangle(t);
      t = hit_triangle(1, 65536);
      t.vertex0_y = 32'sd6553600; t.vertex1_y = 32'sd6553600; t.vertex2_y = 32'sd6553600;
      send_triangle(t);
      t = hit_triangle(0, 65536); send_triangle(t);
      send_triangle(t);
      t.vertex0_y += 1000; t.vertex1_y += 1000; t.vertex2_y += 1000; send_triangle(t);
      t = hit_triangle(1, 65536); send_triangle(t);
      send_triangle(noise_triangle(0));
      t = {{9{32'h8000_0000}}, 1'b1}; send_triangle(t);
      t = {{9{32'h7FFF_FFFF}}, 1'b1}; send_triangle(t);
      drain();

      set_probe(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      t = {32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_0000,
           32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_0000,
           32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1};
      send_triangle(t);
      send_triangle(hit_triangle(1, 65536));
      drain();
      set_probe(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      t = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
           32'h8000_FFFF, 32'h8000_0000, 32'h8000_0000,
           32'h8000_0000, 32'h8000_0000, 32'h8000_FFFF, 1'b1};
      send_triangle(t);
      send_triangle(hit_triangle(1, 65536));
      drain();

      // Random phases, each under its own probe position
      for (int phase = 0; phase < 5; phase++) begin
         if (phase == 4) set_probe($urandom, $urandom, $urandom);
         else set_probe($urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                        $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000,
                        $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000);
         for (int q = 0; q < 120 && sent_items < 1300; q++) begin
            if (phase == 2 && q == 50) begin
               while (board.pending_results.size() != 0) @(posedge clock);
            end
            random_query();
         end
         drain();
      end

      if (board.mismatches == 0 && board.pending_results.size() == 0)
         $display("ground_height_ray_probe_top regression: pass");
      else
         $display("ground_height_ray_probe_top regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
